### design/itpa_pkg.sv
`default_nettype none
package itpa_pkg;

    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned DIGITS_W   = 4 * NUM_DIGITS;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;

    typedef struct packed {
        logic [31:0] value;
        logic        func;
        logic [5:0]  min_length;
        logic        pad_zero;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic       done;
        logic [3:0] ndig;
    } conv_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_SHIFT,
        CV_SCAN
    } conv_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CHAR_ZERO + {4'b0, d};
        end else begin
            r = CHAR_LOW_A + {4'b0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/itpa_conv.sv
`default_nettype none
module itpa_conv (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic                             hex,
    input  wire logic [31:0]                      mag,
    output itpa_pkg::conv_stat_t                  stat,
    output logic [itpa_pkg::DIGITS_W-1:0]         digits
);
    import itpa_pkg::*;

    conv_state_t         state_reg, state_next;
    logic [31:0]         bin_reg, bin_next;
    logic [DIGITS_W-1:0] dig_reg, dig_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [3:0]          ndig_reg, ndig_next;
    logic [DIGITS_W-1:0] adj;
    logic                top_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg  <= bin_next;
        dig_reg  <= dig_next;
        cnt_reg  <= cnt_next;
        ndig_reg <= ndig_next;
    end

    // add-3 correction on every BCD digit before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (dig_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = dig_reg[4*i +: 4];
            end
        end
    end

    assign top_zero = (dig_reg[DIGITS_W-1 -: 4] == 4'd0);

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        ndig_next  = ndig_reg;
        stat.done  = 1'b0;
        stat.ndig  = ndig_reg;
        digits     = dig_reg;
        case (state_reg)
            CV_IDLE: begin
                if (start) begin
                    ndig_next = 4'(NUM_DIGITS);
                    cnt_next  = 5'd0;
                    bin_next  = mag;
                    if (hex) begin
                        dig_next   = {{(DIGITS_W-32){1'b0}}, mag};
                        state_next = CV_SCAN;
                    end else begin
                        dig_next   = '0;
                        state_next = CV_SHIFT;
                    end
                end
            end
            CV_SHIFT: begin
                dig_next = {adj[DIGITS_W-2:0], bin_reg[31]};
                bin_next = {bin_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = CV_SCAN;
                end
            end
            CV_SCAN: begin
                // drop leading zero digits, keep at least one
                if (!top_zero || ndig_reg == 4'd1) begin
                    stat.done  = 1'b1;
                    state_next = CV_IDLE;
                end else begin
                    dig_next  = {dig_reg[DIGITS_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 4'd1;
                end
            end
            default: begin
                state_next = CV_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/int_to_padded_ascii.sv
`default_nettype none
// Converts a 32-bit value to ASCII text, one character per output word, most
// significant first, with last set on the final character. func=0 prints
// signed decimal, func=1 prints the raw bits in lower-case hex. Pad characters
// (space or '0' per pad_zero) lead the text, ahead of any '-', until
// min_length (clamped to MAX_MIN_LENGTH) characters are reached. Decimal
// conversion runs a bit-serial shift-add-3 over all 32 bits and then drops
// leading zero digits, one per cycle and up to 9; hex conversion only drops
// the leading zero digits. Characters are then emitted one per cycle unless
// the output stalls; after the last one the block returns to idle, where the
// next number can be taken. A new number is accepted once the last character
// of the previous one is in the output register.
module int_to_padded_ascii #(
    parameter int MAX_MIN_LENGTH = 63
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire itpa_pkg::in_word_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output itpa_pkg::out_word_t     m_data
);
    import itpa_pkg::*;

    localparam logic [5:0] MAX_LEN = 6'(MAX_MIN_LENGTH);

    top_state_t          state_reg, state_next;
    logic                neg_reg, neg_next;
    logic                padz_reg, padz_next;
    logic [5:0]          minlen_reg, minlen_next;
    logic [5:0]          pad_reg, pad_next;
    logic [3:0]          dcnt_reg, dcnt_next;
    logic [DIGITS_W-1:0] dig_reg, dig_next;
    logic                m_valid_reg, m_valid_next;
    out_word_t           m_data_reg, m_data_next;

    logic                accept;
    logic                neg_in;
    logic [31:0]         mag;
    conv_stat_t          cstat;
    logic [DIGITS_W-1:0] cdigits;
    logic [4:0]          txt_len;
    logic                slot_free;

    assign accept = s_valid && s_ready;
    assign neg_in = !s_data.func && s_data.value[31];
    assign mag    = neg_in ? (32'd0 - s_data.value) : s_data.value;

    itpa_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .hex     (s_data.func),
        .mag     (mag),
        .stat    (cstat),
        .digits  (cdigits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        neg_reg    <= neg_next;
        padz_reg   <= padz_next;
        minlen_reg <= minlen_next;
        pad_reg    <= pad_next;
        dcnt_reg   <= dcnt_next;
        dig_reg    <= dig_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign txt_len   = {1'b0, cstat.ndig} + {4'd0, neg_reg};

    always_comb begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        padz_next    = padz_reg;
        minlen_next  = minlen_reg;
        pad_next     = pad_reg;
        dcnt_next    = dcnt_reg;
        dig_next     = dig_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next    = neg_in;
                    padz_next   = s_data.pad_zero;
                    minlen_next = (s_data.min_length > MAX_LEN) ? MAX_LEN
                                                                : s_data.min_length;
                    state_next  = ST_CONV;
                end
            end
            ST_CONV: begin
                if (cstat.done) begin
                    dig_next  = cdigits;
                    dcnt_next = cstat.ndig;
                    if (minlen_reg > {1'b0, txt_len}) begin
                        pad_next = minlen_reg - {1'b0, txt_len};
                    end else begin
                        pad_next = 6'd0;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    if (pad_reg != 6'd0) begin
                        m_data_next.out_char = padz_reg ? CHAR_ZERO : CHAR_SPACE;
                        m_data_next.last     = 1'b0;
                        pad_next             = pad_reg - 6'd1;
                    end else if (neg_reg) begin
                        m_data_next.out_char = CHAR_MINUS;
                        m_data_next.last     = 1'b0;
                        neg_next             = 1'b0;
                    end else begin
                        m_data_next.out_char = digit_char(dig_reg[DIGITS_W-1 -: 4]);
                        m_data_next.last     = (dcnt_reg == 4'd1);
                        dig_next             = {dig_reg[DIGITS_W-5:0], 4'd0};
                        dcnt_next            = dcnt_reg - 4'd1;
                        if (dcnt_reg == 4'd1) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/itpa_check.sv
`default_nettype none
module itpa_check (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire itpa_pkg::in_word_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire itpa_pkg::out_word_t m_data
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken again too soon after a word");

    a_no_accept_midtext: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("input ready before the last character was produced");

    a_char_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.out_char != 8'd0)
        else $error("NUL character on output");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

endmodule

bind int_to_padded_ascii itpa_check u_itpa_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
